// File: design/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants for the slope line rasteriser
// Coordinate width, stream word layout, sequencer states and the structs
// passed between the divider, the slope stepper and the top level.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int COORD_W       = 6;
    localparam int COORD_MAX     = (2 ** COORD_W) - 1;
    localparam int GRID_SIZE_DEF = 64;

    // four coordinates in, packed from the lowest bit up
    localparam int S_TDATA_W = 24;
    // pixel_x, pixel_y, padded to whole bytes
    localparam int M_TDATA_W = 16;

    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_VERT,
        ST_HORZ,
        ST_SLOPE
    } slr_state_t;

    // divider result, valid for one cycle when done is high
    typedef struct packed {
        logic   done;
        coord_t quo;
        coord_t rmd;
    } div_res_t;

    // slope stepper control
    typedef struct packed {
        logic load;
        logic step;
    } dda_ctl_t;

endpackage

// File: design/slr_div.sv
// ----------------------------------------------------------------------------
// slr_div: bit-serial restoring divider
// Produces one quotient bit per cycle, MSB first; the dividend register
// shifts out dividend bits and shifts in quotient bits.
// ----------------------------------------------------------------------------
module slr_div
    import slr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  coord_t   dividend,
    input  coord_t   divisor,
    output div_res_t res
);

    localparam int CNT_W = $clog2(COORD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    coord_t           dvd_reg, dvd_next;
    coord_t           dvs_reg, dvs_next;
    coord_t           rem_reg, rem_next;
    logic [COORD_W:0] partial;
    logic             qbit;

    always_comb begin
        partial   = {rem_reg, dvd_reg[COORD_W-1]};
        qbit      = (partial >= {1'b0, dvs_reg});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            cnt_next = CNT_W'(COORD_W);
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            dvd_next  = {dvd_reg[COORD_W-2:0], qbit};
            rem_next  = qbit ? COORD_W'(partial - {1'b0, dvs_reg})
                             : partial[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quo  = dvd_reg;
    assign res.rmd  = rem_reg;

endmodule

// File: design/slr_dda.sv
// ----------------------------------------------------------------------------
// slr_dda: slope stepper
// Holds the current row and the fractional remainder; each step adds the
// floored whole part of dy/dx and carries when the remainder wraps.
// ----------------------------------------------------------------------------
module slr_dda
    import slr_pkg::*;
(
    input  logic     aclk,
    input  dda_ctl_t ctl,
    input  coord_t   y_init,
    input  coord_t   quo,
    input  coord_t   rmd,
    input  logic     dy_neg,
    input  coord_t   dx,
    output coord_t   y_out
);

    coord_t           y_reg, y_next;
    coord_t           acc_reg, acc_next;
    coord_t           inc_reg, inc_next;
    coord_t           frac_reg, frac_next;
    logic [COORD_W:0] sum;

    always_comb begin
        sum       = {1'b0, acc_reg} + {1'b0, frac_reg};
        y_next    = y_reg;
        acc_next  = acc_reg;
        inc_next  = inc_reg;
        frac_next = frac_reg;
        if (ctl.load) begin
            // floor of a negative quotient: one further down when inexact
            y_next   = y_init;
            acc_next = '0;
            if (dy_neg && (rmd != '0)) begin
                inc_next  = ~quo;
                frac_next = dx - rmd;
            end else if (dy_neg) begin
                inc_next  = -quo;
                frac_next = '0;
            end else begin
                inc_next  = quo;
                frac_next = rmd;
            end
        end else if (ctl.step) begin
            if (sum >= {1'b0, dx}) begin
                acc_next = COORD_W'(sum - {1'b0, dx});
                y_next   = y_reg + inc_reg + 1'b1;
            end else begin
                acc_next = sum[COORD_W-1:0];
                y_next   = y_reg + inc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        inc_reg  <= inc_next;
        frac_reg <= frac_next;
    end

    assign y_out = y_reg;

endmodule

// File: design/slope_line_rasterizer.sv
// ----------------------------------------------------------------------------
// slope_line_rasterizer: line segment to pixel stream
// Takes one segment per input word and streams out the pixels to set.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one word per segment, both endpoints as pixel coordinates.
//   m_ channel: one word per pixel; m_tlast marks the final pixel of a segment.
//   Vertical segments walk y upwards, horizontal ones walk x upwards, and a
//   single point comes out twice (vertical pass, then horizontal pass).
//   Any other segment gives one pixel per column, x ascending, with the row
//   on the exact line through both endpoints, rounded down.
// Sequence
//   Sloped segment: the word is taken, the bit-serial divider forms |dy|/dx
//   (one quotient bit a cycle), the stepper is loaded, then one pixel a
//   cycle while the m_ side does not stall.
//   Straight segment or point: one pixel a cycle from the walk state, while
//   the m_ side does not stall.
// Reset and stall
//   aresetn (synchronous, active low) empties the output register and returns
//   the sequencer to idle. A stalled m_ side holds the word and freezes the
//   walk; s_tready rises again as soon as the final pixel is registered.
// ----------------------------------------------------------------------------
module slope_line_rasterizer
    import slr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // x_start [5:0], y_start [11:6], x_end [17:12], y_end [23:18]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // pixel_x [5:0], pixel_y [11:6], zero [15:12]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // last_pixel
    output logic                 m_tlast
);

    // coordinates at or above the grid saturate to its last pixel
    localparam int     CLAMP_MAX = (GRID_SIZE - 1 < COORD_MAX) ? GRID_SIZE - 1 : COORD_MAX;
    localparam coord_t CLAMP_VAL = COORD_W'(CLAMP_MAX);

    slr_state_t state_reg, state_next;

    // captured segment
    coord_t cnt_reg;
    coord_t lo_x_reg, hi_x_reg, hi_y_reg;
    coord_t col_reg, row_reg, y0_reg, dx_reg;
    logic   horz_reg, dy_neg_reg;

    // output word register
    logic   m_tvalid_reg;
    coord_t px_reg, py_reg;
    logic   last_reg;

    coord_t xs_c, ys_c, xe_c, ye_c;
    coord_t lo_x_c, hi_x_c, lo_y_c, hi_y_c;
    logic   vert_c, horz_c, x_up_c, dy_neg_c;
    logic   s_accept, slot_free, emit, end_walk;
    coord_t px, py;
    logic   plast;

    div_res_t div_res;
    dda_ctl_t dda_ctl;
    coord_t   dda_y;

    // ---- input decode -------------------------------------------------------
    always_comb begin
        xs_c = (s_tdata[COORD_W-1:0] > CLAMP_VAL) ? CLAMP_VAL : s_tdata[COORD_W-1:0];
        ys_c = (s_tdata[2*COORD_W-1:COORD_W] > CLAMP_VAL) ? CLAMP_VAL
                                                          : s_tdata[2*COORD_W-1:COORD_W];
        xe_c = (s_tdata[3*COORD_W-1:2*COORD_W] > CLAMP_VAL) ? CLAMP_VAL
                                                            : s_tdata[3*COORD_W-1:2*COORD_W];
        ye_c = (s_tdata[4*COORD_W-1:3*COORD_W] > CLAMP_VAL) ? CLAMP_VAL
                                                            : s_tdata[4*COORD_W-1:3*COORD_W];
        x_up_c   = (xs_c < xe_c);
        lo_x_c   = x_up_c ? xs_c : xe_c;
        hi_x_c   = x_up_c ? xe_c : xs_c;
        lo_y_c   = (ys_c < ye_c) ? ys_c : ye_c;
        hi_y_c   = (ys_c < ye_c) ? ye_c : ys_c;
        vert_c   = (xs_c == xe_c);
        horz_c   = (ys_c == ye_c);
        // sign of dy once dx is made positive
        dy_neg_c = x_up_c ? (ye_c < ys_c) : (ys_c < ye_c);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    // ---- sequencer: next state ----------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (vert_c) begin
                        state_next = ST_VERT;
                    end else if (horz_c) begin
                        state_next = ST_HORZ;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = ST_SLOPE;
                end
            end
            ST_VERT: begin
                if (emit && end_walk) begin
                    state_next = horz_reg ? ST_HORZ : ST_IDLE;
                end
            end
            ST_HORZ, ST_SLOPE: begin
                if (emit && end_walk) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs -------------------------------------------------
    always_comb begin
        emit         = 1'b0;
        end_walk     = 1'b0;
        px           = cnt_reg;
        py           = row_reg;
        plast        = 1'b0;
        dda_ctl.load = 1'b0;
        dda_ctl.step = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_DIV: begin
                dda_ctl.load = div_res.done;
            end
            ST_VERT: begin
                emit     = slot_free;
                end_walk = (cnt_reg == hi_y_reg);
                px       = col_reg;
                py       = cnt_reg;
                // a point also takes the horizontal pass, which ends it
                plast    = end_walk && !horz_reg;
            end
            ST_HORZ: begin
                emit     = slot_free;
                end_walk = (cnt_reg == hi_x_reg);
                plast    = end_walk;
            end
            ST_SLOPE: begin
                emit         = slot_free;
                end_walk     = (cnt_reg == hi_x_reg);
                py           = dda_y;
                plast        = end_walk;
                dda_ctl.step = slot_free;
            end
            default: begin
            end
        endcase
    end

    // ---- registers ----------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end

        if (emit) begin
            px_reg   <= px;
            py_reg   <= py;
            last_reg <= plast;
        end

        if (s_accept) begin
            lo_x_reg   <= lo_x_c;
            hi_x_reg   <= hi_x_c;
            hi_y_reg   <= hi_y_c;
            col_reg    <= xs_c;
            row_reg    <= ys_c;
            y0_reg     <= x_up_c ? ys_c : ye_c;
            dx_reg     <= hi_x_c - lo_x_c;
            horz_reg   <= horz_c;
            dy_neg_reg <= dy_neg_c;
            cnt_reg    <= vert_c ? lo_y_c : lo_x_c;
        end else if (emit) begin
            if ((state_reg == ST_VERT) && end_walk) begin
                cnt_reg <= lo_x_reg;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // ---- slope: |dy| / dx, then one step per column -------------------------
    slr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept && !vert_c && !horz_c),
        .dividend (hi_y_c - lo_y_c),
        .divisor  (hi_x_c - lo_x_c),
        .res      (div_res)
    );

    slr_dda u_dda (
        .aclk   (aclk),
        .ctl    (dda_ctl),
        .y_init (y0_reg),
        .quo    (div_res.quo),
        .rmd    (div_res.rmd),
        .dy_neg (dy_neg_reg),
        .dx     (dx_reg),
        .y_out  (dda_y)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*COORD_W){1'b0}}, py_reg, px_reg};
    assign m_tlast  = last_reg;

endmodule

// File: design/slr_checker.sv
// ----------------------------------------------------------------------------
// slr_checker: port-level checks for the slope line rasteriser
// Watches both stream channels and flags ordering and hold violations.
// ----------------------------------------------------------------------------
module slr_checker
    import slr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic                 m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // one segment at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second segment taken straight after the first");

    // mid-segment pixel means the walk is still running
    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready before segment finished");

    // padding bits stay clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:2*COORD_W] == '0))
        else $error("non-zero padding in output word");

endmodule

bind slope_line_rasterizer slr_checker u_slr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
